@@ design/wsdf_pkg.sv @@
// Package for the WebSocket frame deframer.
// Holds the parse phase encoding, the framing constants and the result word type.
// Has no dependencies.
package wsdf_pkg;

  // Width of a decoded payload length; the top bit of a 64-bit length is dropped.
  localparam int LEN_W = 63;

  // Length codes in the second header byte.
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // Extended-length byte counts; zero stands for eight bytes.
  localparam logic [2:0] EXT16_BYTES = 3'd2;
  localparam logic [2:0] EXT64_BYTES = 3'd0;

  // Number of masking key bytes.
  localparam logic [2:0] KEY_BYTES = 3'd4;

  // Parse phases, one-hot.
  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  // Result word fields, listed from the highest bit down.
  typedef struct packed {
    logic [LEN_W-1:0] frame_length;
    logic             was_masked;
    logic [2:0]       reserved_bits;
    logic             final_fragment;
    logic [3:0]       frame_opcode;
    logic [7:0]       payload_byte;
  } data_t;

  // One result word with its side-band flags.
  typedef struct packed {
    logic  last_of_frame;
    logic  header_only;
    data_t data;
  } result_t;

endpackage

@@ design/websocket_frame_deframer.sv @@
// WebSocket frame deframer top level: header parsing, payload unmasking and
// a two-entry output stage. Depends on wsdf_pkg.
//
// While ready, the block takes one stream byte per clock and parses back-to-back
// WebSocket frames: two header bytes, an optional 16-bit or 64-bit big-endian
// extended length, an optional 4-byte masking key, then the payload. Every
// payload byte leaves as one word, unmasked, with tlast on the final byte of
// the frame; a frame with zero payload leaves as one header-only word (tuser
// set, tlast set, payload byte zero). Header bytes produce no word. Each byte
// is handled combinationally by the parser and its result is registered,
// so the input sustains one byte per clock while no skid word waits; a skid
// entry behind the output register holds one more word, so the input stays
// ready while the output is stalled until that entry fills.
// Words are registered in the output register, or the skid entry on a stall.
module websocket_frame_deframer
  import wsdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] stream_byte
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [7:0] payload_byte, [11:8] frame_opcode,
                                 // [12] final_fragment, [15:13] reserved_bits,
                                 // [16] was_masked, [79:17] frame_length
  output logic        m_tlast,   // last_of_frame
  output logic        m_tuser    // header_only
);

  // Parser state.
  phase_t           phase, phase_next;
  logic             fin, fin_next;
  logic [2:0]       rsv, rsv_next;
  logic [3:0]       opcode, opcode_next;
  logic             masked, masked_next;
  logic [LEN_W-1:0] acc, acc_next;
  logic [LEN_W-1:0] remaining, remaining_next;
  logic [31:0]      key, key_next;
  logic [2:0]       count, count_next;
  logic [1:0]       kidx, kidx_next;

  logic             len_done;
  logic             hdr_done;
  logic             emit;
  logic [7:0]       key_byte;
  result_t          res;

  // Output stage.
  result_t          out_word;
  result_t          skid_word;
  logic             skid_valid;
  logic             accept;
  logic             out_load;

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign out_load = !m_tvalid || m_tready;

  // Key byte for the current payload position; first key byte is the high byte.
  always_comb begin
    case (kidx)
      2'd0:    key_byte = key[31:24];
      2'd1:    key_byte = key[23:16];
      2'd2:    key_byte = key[15:8];
      2'd3:    key_byte = key[7:0];
      default: key_byte = key[31:24];
    endcase
  end

  // Header parsing and payload unmasking for one byte.
  always_comb begin
    phase_next     = phase;
    fin_next       = fin;
    rsv_next       = rsv;
    opcode_next    = opcode;
    masked_next    = masked;
    acc_next       = acc;
    remaining_next = remaining;
    key_next       = key;
    count_next     = count;
    kidx_next      = kidx;
    len_done       = 1'b0;
    hdr_done       = 1'b0;
    emit           = 1'b0;
    res            = '0;

    case (phase)
      PH_HDR1: begin
        masked_next = s_tdata[7];
        count_next  = '0;
        acc_next    = '0;
        if (s_tdata[6:0] == LEN_CODE_EXT16) begin
          count_next = EXT16_BYTES;
          phase_next = PH_EXTLEN;
        end else if (s_tdata[6:0] == LEN_CODE_EXT64) begin
          count_next = EXT64_BYTES;
          phase_next = PH_EXTLEN;
        end else begin
          acc_next = {{(LEN_W-7){1'b0}}, s_tdata[6:0]};
          len_done = 1'b1;
        end
      end
      PH_EXTLEN: begin
        // Shifting into a 63-bit register drops the top bit of a 64-bit length.
        acc_next   = {acc[LEN_W-9:0], s_tdata};
        count_next = count - 3'd1;
        if (count_next == 3'd0) begin
          len_done = 1'b1;
        end
      end
      PH_KEY: begin
        key_next   = {key[23:0], s_tdata};
        count_next = count + 3'd1;
        if (count_next == KEY_BYTES) begin
          count_next = '0;
          hdr_done   = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        kidx_next         = kidx + 2'd1;
        remaining_next    = remaining - {{(LEN_W-1){1'b0}}, 1'b1};
        emit              = 1'b1;
        res.data.payload_byte = s_tdata ^ key_byte;
        res.last_of_frame = (remaining == {{(LEN_W-1){1'b0}}, 1'b1});
        if (res.last_of_frame) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        fin_next    = s_tdata[7];
        rsv_next    = s_tdata[6:4];
        opcode_next = s_tdata[3:0];
        phase_next  = PH_HDR1;
      end
    endcase

    // Length known: collect the key if masked, else the header is complete.
    if (len_done) begin
      key_next = '0;
      if (masked_next) begin
        phase_next = PH_KEY;
        count_next = '0;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // Header complete: start the payload or report an empty frame.
    if (hdr_done) begin
      remaining_next = acc_next;
      kidx_next      = '0;
      if (acc_next == '0) begin
        emit              = 1'b1;
        res.last_of_frame = 1'b1;
        res.header_only   = 1'b1;
        phase_next        = PH_HDR0;
      end else begin
        phase_next = PH_PAYLOAD;
      end
    end

    res.data.frame_opcode   = opcode_next;
    res.data.final_fragment = fin_next;
    res.data.reserved_bits  = rsv_next;
    res.data.was_masked     = masked_next;
    res.data.frame_length   = acc_next;
    emit = emit && accept;
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR0;
      fin       <= 1'b0;
      rsv       <= '0;
      opcode    <= '0;
      masked    <= 1'b0;
      acc       <= '0;
      remaining <= '0;
      key       <= '0;
      count     <= '0;
      kidx      <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      fin       <= fin_next;
      rsv       <= rsv_next;
      opcode    <= opcode_next;
      masked    <= masked_next;
      acc       <= acc_next;
      remaining <= remaining_next;
      key       <= key_next;
      count     <= count_next;
      kidx      <= kidx_next;
    end
  end

  // Output and skid valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_load) begin
      m_tvalid   <= skid_valid || emit;
      skid_valid <= 1'b0;
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  // Output and skid words.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word <= skid_valid ? skid_word : res;
    end else if (emit) begin
      skid_word <= res;
    end
  end

  assign m_tdata = out_word.data;
  assign m_tlast = out_word.last_of_frame;
  assign m_tuser = out_word.header_only;

  // The skid entry is only filled behind a stalled output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry valid without an output word");

  // A header-only word always closes its frame.
  a_hdr_only_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("header-only word without last flag");

  // A header-only word carries no byte and a zero length.
  a_hdr_only_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[7:0] == 8'd0 && m_tdata[79:17] == '0))
    else $error("header-only word with payload or length");

  // While in the payload, at least one byte is still expected.
  a_payload_nonempty: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (remaining != '0))
    else $error("payload phase with no bytes remaining");

endmodule

@@ tb/sv/websocket_frame_deframer_tb.sv @@
// Self-checking testbench for the WebSocket frame deframer.
// Sends back-to-back frames byte by byte and checks every output word against a built-in parser.
// Depends on wsdf_pkg and websocket_frame_deframer.
`timescale 1ns / 100ps

module websocket_frame_deframer_tb
  import wsdf_pkg::*;
();

  localparam int STREAM_TARGET     = 1250;
  localparam int DRAIN_POINT       = 400;
  localparam int LONG_STALL_AT     = 700;
  localparam int LONG_STALL_CYCLES = 300;
  localparam int QUIET_TAIL        = 200;
  localparam int CYCLE_LIMIT       = 200000;

  // How the payload length is encoded in the header.
  typedef enum logic [1:0] {
    FORM_SHORT,
    FORM_EXT16,
    FORM_EXT64
  } len_form_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  // Stream bytes still to send and words the parser expects, oldest first.
  logic [7:0] stream_bytes[$];
  result_t    expected_words[$];

  int total_bytes = 0;
  int sent_count = 0;
  int error_count = 0;
  int cycle_count = 0;

  // Parser state mirrored by the testbench.
  phase_t      ph;
  logic        hdr_fin;
  logic [2:0]  hdr_rsv;
  logic [3:0]  hdr_opcode;
  logic        hdr_mask;
  logic [63:0] len_acc;
  logic [63:0] remaining;
  logic [31:0] mkey;
  logic [2:0]  sub_cnt;
  logic [1:0]  key_idx;

  websocket_frame_deframer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idling runs in alternating windows and stops near the end of the stream.
  function automatic logic idling_on();
    return (sent_count + QUIET_TAIL < total_bytes) && ((sent_count / 150) % 3 != 2);
  endfunction

  // ---------------------------------------------------------------------------
  // Frame parser used to predict the output words.
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [7:0] data, input logic last, input logic hdr_only);
    result_t w;
    w.last_of_frame       = last;
    w.header_only         = hdr_only;
    w.data.payload_byte   = data;
    w.data.frame_opcode   = hdr_opcode;
    w.data.final_fragment = hdr_fin;
    w.data.reserved_bits  = hdr_rsv;
    w.data.was_masked     = hdr_mask;
    w.data.frame_length   = len_acc[LEN_W-1:0];
    expected_words.insert(expected_words.size(), w);
  endtask

  // Header complete: a zero-length frame produces its header-only word here.
  task automatic start_payload();
    remaining = len_acc;
    key_idx = 2'd0;
    if (remaining == 64'd0) begin
      push_word(8'h00, 1'b1, 1'b1);
      ph = PH_HDR0;
    end else begin
      ph = PH_PAYLOAD;
    end
  endtask

  // Length known; the top bit of a 64-bit length is dropped.
  task automatic finish_length();
    len_acc[63] = 1'b0;
    mkey = 32'd0;
    if (hdr_mask) begin
      ph = PH_KEY;
      sub_cnt = 3'd0;
    end else begin
      start_payload();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] key_byte;
    case (ph)
      PH_HDR1: begin
        hdr_mask = b[7];
        sub_cnt = 3'd0;
        len_acc = 64'd0;
        if (b[6:0] == LEN_CODE_EXT16) begin
          sub_cnt = EXT16_BYTES;
          ph = PH_EXTLEN;
        end else if (b[6:0] == LEN_CODE_EXT64) begin
          sub_cnt = EXT64_BYTES;
          ph = PH_EXTLEN;
        end else begin
          len_acc = {57'd0, b[6:0]};
          finish_length();
        end
      end
      PH_EXTLEN: begin
        len_acc = {len_acc[55:0], b};
        sub_cnt = sub_cnt - 3'd1;
        if (sub_cnt == 3'd0) finish_length();
      end
      PH_KEY: begin
        mkey = {mkey[23:0], b};
        sub_cnt = sub_cnt + 3'd1;
        if (sub_cnt == KEY_BYTES) begin
          sub_cnt = 3'd0;
          start_payload();
        end
      end
      PH_PAYLOAD: begin
        key_byte = mkey[31 - 8 * key_idx -: 8];
        key_idx = key_idx + 2'd1;
        remaining = remaining - 64'd1;
        push_word(b ^ key_byte, remaining == 64'd0, 1'b0);
        if (remaining == 64'd0) ph = PH_HDR0;
      end
      default: begin
        hdr_fin = b[7];
        hdr_rsv = b[6:4];
        hdr_opcode = b[3:0];
        ph = PH_HDR1;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b);
    stream_bytes.insert(stream_bytes.size(), b);
  endtask

  task automatic queue_frame(input logic [7:0] first_byte, input logic masked,
                             input len_form_t form, input logic [63:0] len_value,
                             input int unsigned pay_n);
    queue_byte(first_byte);
    case (form)
      FORM_SHORT: queue_byte({masked, len_value[6:0]});
      FORM_EXT16: begin
        queue_byte({masked, LEN_CODE_EXT16});
        queue_byte(len_value[15:8]);
        queue_byte(len_value[7:0]);
      end
      default: begin
        queue_byte({masked, LEN_CODE_EXT64});
        for (int i = 7; i >= 0; i--) queue_byte(len_value[8*i +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 0; i < 4; i++) queue_byte(8'($urandom_range(0, 255)));
    end
    for (int unsigned i = 0; i < pay_n; i++) queue_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned n;
    int unsigned pick;
    logic masked;

    // Zero-length frames complete on the length byte, the extended length or the key.
    queue_frame(8'h81, 1'b0, FORM_SHORT, 64'd0, 0);
    queue_frame(8'h89, 1'b1, FORM_SHORT, 64'd0, 0);
    queue_frame(8'h8A, 1'b0, FORM_EXT16, 64'd0, 0);
    // Top bit of a 64-bit length is ignored, leaving a zero length.
    queue_frame(8'h88, 1'b1, FORM_EXT64, 64'h8000_0000_0000_0000, 0);
    // Reserved and opcode bits set, final flag clear, masked payload.
    queue_frame(8'h7F, 1'b1, FORM_SHORT, 64'd5, 5);
    // All header bits clear, unmasked payload passes through.
    queue_frame(8'h00, 1'b0, FORM_SHORT, 64'd3, 3);
    queue_frame(8'h01, 1'b1, FORM_EXT16, 64'd3, 3);
    queue_frame(8'h82, 1'b0, FORM_EXT64, 64'h8000_0000_0000_0002, 2);

    // Random well-formed frames, mostly short ones.
    while (stream_bytes.size() < STREAM_TARGET) begin
      pick = $urandom_range(0, 9);
      masked = ($urandom_range(0, 2) != 0);
      if (pick < 7) begin
        n = ($urandom_range(0, 15) == 0) ? 125 : $urandom_range(0, 24);
        queue_frame(8'($urandom_range(0, 255)), masked, FORM_SHORT, 64'(n), n);
      end else if (pick < 9) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 40);
        queue_frame(8'($urandom_range(0, 255)), masked, FORM_EXT16, 64'(n), n);
      end else begin
        n = $urandom_range(0, 40);
        queue_frame(8'($urandom_range(0, 255)), masked, FORM_EXT64,
                    {1'($urandom_range(0, 1)), 47'd0, 16'(n)}, n);
      end
    end

    // Largest length last: the frame stays open while its first bytes are checked.
    queue_frame(8'h82, 1'b1, FORM_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, 48);
    total_bytes = stream_bytes.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    wait (sent_count == total_bytes);
    wait (expected_words.size() == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender: presents one byte at a time, with random gaps and one drain pause.
  // ---------------------------------------------------------------------------
  logic       drv_valid;
  logic [7:0] drv_data;
  int         src_gap = 0;
  int         sent_next = 0;

  always @(posedge clk) begin
    if (rst) begin
      ph = PH_HDR0;
      hdr_fin = 1'b0;
      hdr_rsv = 3'd0;
      hdr_opcode = 4'd0;
      hdr_mask = 1'b0;
      len_acc = 64'd0;
      remaining = 64'd0;
      mkey = 32'd0;
      sub_cnt = 3'd0;
      key_idx = 2'd0;
      src_gap = 0;
      s_tvalid <= 1'b0;
      s_tdata <= 8'h00;
    end else begin
      drv_valid = s_tvalid;
      drv_data = s_tdata;
      sent_next = sent_count;
      if (s_tvalid && s_tready) begin
        deframe_byte(s_tdata);
        sent_next = sent_count + 1;
        sent_count <= sent_next;
        drv_valid = 1'b0;
        if (idling_on() && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 7);
      end
      if (!drv_valid) begin
        if (sent_next == DRAIN_POINT && expected_words.size() != 0) begin
          // Hold the next byte until every expected word has come out.
        end else if (src_gap > 0) begin
          src_gap--;
        end else if (stream_bytes.size() > 0) begin
          drv_valid = 1'b1;
          drv_data = stream_bytes.pop_front();
        end
      end
      s_tvalid <= drv_valid;
      s_tdata <= drv_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts plus one long hold-off to back up the input.
  // ---------------------------------------------------------------------------
  int   stall_left = 0;
  logic long_stall_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!long_stall_done && sent_count >= LONG_STALL_AT) begin
      long_stall_done = 1'b1;
      stall_left = LONG_STALL_CYCLES - 1;
      m_tready <= 1'b0;
    end else if (idling_on() && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Output checker.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [62:0] want_v,
                             input logic [62:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
      error_count++;
    end
  endtask

  result_t want;
  data_t   got;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: tdata=%h tlast=%b tuser=%b", m_tdata, m_tlast, m_tuser);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        got = m_tdata;
        check_field("payload_byte", 63'(want.data.payload_byte), 63'(got.payload_byte));
        check_field("frame_opcode", 63'(want.data.frame_opcode), 63'(got.frame_opcode));
        check_field("final_fragment", 63'(want.data.final_fragment),
                    63'(got.final_fragment));
        check_field("reserved_bits", 63'(want.data.reserved_bits), 63'(got.reserved_bits));
        check_field("was_masked", 63'(want.data.was_masked), 63'(got.was_masked));
        check_field("frame_length", want.data.frame_length, got.frame_length);
        check_field("last_of_frame", 63'(want.last_of_frame), 63'(m_tlast));
        check_field("header_only", 63'(want.header_only), 63'(m_tuser));
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
